// ===== src/rbd_pkg.sv =====
// rbd_pkg: shared types, constants and pointer helpers for the ring buffer deque.
// No dependencies; rbd_if and ring_buffer_deque import this package.
`default_nettype none

package rbd_pkg;

   localparam int DEPTH    = 512;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 10;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SWAP       = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FEW  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_SWAP = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   function automatic addr_type step_fwd(input addr_type p);
      return (p == ADDR_W'(DEPTH - 1)) ? '0 : addr_type'(p + 1'b1);
   endfunction

   function automatic addr_type step_back(input addr_type p);
      return (p == '0) ? ADDR_W'(DEPTH - 1) : addr_type'(p - 1'b1);
   endfunction

endpackage

`default_nettype wire

// ===== src/rbd_if.sv =====
// rbd_if: valid/ready channel interfaces for requests and responses.
// Depends on rbd_pkg for field widths.
`default_nettype none

interface rbd_req_if import rbd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, kind, push_value, input ready);
   modport sink   (input valid, kind, push_value, output ready);
endinterface

interface rbd_rsp_if import rbd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] pop_value;
   logic [STATUS_W-1:0]      status;
   logic [COUNT_W-1:0]       count;

   modport source (output valid, pop_value, status, count, input ready);
   modport sink   (input valid, pop_value, status, count, output ready);
endinterface

`default_nettype wire

// ===== src/ring_buffer_deque.sv =====
// ring_buffer_deque: double-ended queue of 32-bit words in a ring memory.
// Depends on rbd_pkg, rbd_if (rbd_req_if, rbd_rsp_if) and rbd_ram.
//
//   channel   dir  fields                    moves
//   req_chan  in   kind, push_value          one operation per request
//   rsp_chan  out  pop_value, status, count  one response per request
//
// Push and rejected requests go to ST_DONE at once; pops pass ST_READ (memory read
// latency); swap reads both entries, then writes in ST_READ and ST_SWAP (one port).
// A request is taken in idle, or in the cycle its predecessor's response moves
// into the output register. Reset (synchronous) empties the deque at once; the
// memory is not cleared. A stalled rsp_chan holds one response and the next
// request still runs up to its own response.
`default_nettype none

module ring_buffer_deque import rbd_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   rbd_req_if.sink   req_chan,
   rbd_rsp_if.source rsp_chan
);

   state_type state_ff, state_in;
   addr_type  front_ff, front_in;
   addr_type  back_ff, back_in;
   cnt_type   count_ff, count_in;

   logic [DATA_W-1:0]   hold_pop_ff, hold_pop_in;
   logic [STATUS_W-1:0] hold_status_ff, hold_status_in;
   addr_type            swap_b_ff, swap_b_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_pop_ff, rsp_pop_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic              out_free, accept, full, empty;
   logic              ram_we;
   addr_type          ram_waddr, ram_raddr_a, ram_raddr_b;
   logic [DATA_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

   rbd_ram #(
      .DATA_W (DATA_W),
      .ADDR_W (ADDR_W),
      .DEPTH  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (ram_rdata_a),
      .rdata_b (ram_rdata_b)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) || (state_ff == ST_DONE && out_free);
   assign accept = req_chan.valid && req_chan.ready;
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // read ports are free-running; data is used only in ST_READ
   assign ram_raddr_a = (req_chan.kind == KIND_POP_BACK) ? step_back(back_ff) : front_ff;
   assign ram_raddr_b = step_fwd(front_ff);

   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      back_in        = back_ff;
      count_in       = count_ff;
      hold_pop_in    = hold_pop_ff;
      hold_status_in = hold_status_ff;
      swap_b_in      = swap_b_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_pop_in     = rsp_pop_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      ram_we         = 1'b0;
      ram_waddr      = front_ff;
      ram_wdata      = req_chan.push_value;

      unique case (state_ff)
         ST_IDLE: ;
         ST_READ: begin
            if (hold_status_ff == STATUS_DONE && swap_b_ff == step_fwd(front_ff)
                && hold_pop_ff == '1) begin
               // swap: front <- second, keep front word for the second write
               ram_we      = 1'b1;
               ram_waddr   = front_ff;
               ram_wdata   = ram_rdata_b;
               hold_pop_in = ram_rdata_a;
               state_in    = ST_SWAP;
            end else begin
               hold_pop_in = ram_rdata_a;
               state_in    = ST_DONE;
            end
         end
         ST_SWAP: begin
            ram_we      = 1'b1;
            ram_waddr   = swap_b_ff;
            ram_wdata   = hold_pop_ff;
            hold_pop_in = '0;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pop_in    = hold_pop_ff;
               rsp_status_in = hold_status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (accept) begin
         hold_pop_in    = '0;
         hold_status_in = STATUS_DONE;
         state_in       = ST_DONE;
         unique case (req_chan.kind) inside
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
               if (full) begin
                  hold_status_in = STATUS_FULL;
               end else begin
                  ram_we   = 1'b1;
                  count_in = cnt_type'(count_ff + 1'b1);
                  if (req_chan.kind == KIND_PUSH_FRONT) begin
                     ram_waddr = step_back(front_ff);
                     front_in  = step_back(front_ff);
                  end else begin
                     ram_waddr = back_ff;
                     back_in   = step_fwd(back_ff);
                  end
               end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
               if (empty) begin
                  hold_status_in = STATUS_FEW;
               end else begin
                  count_in = cnt_type'(count_ff - 1'b1);
                  state_in = ST_READ;
                  if (req_chan.kind == KIND_POP_FRONT) begin
                     front_in = step_fwd(front_ff);
                  end else begin
                     back_in = step_back(back_ff);
                  end
                  swap_b_in = '0;
                  if (step_fwd(front_ff) == '0) begin
                     swap_b_in = ADDR_W'(1);
                  end
               end
            end
            KIND_SWAP: begin
               if (count_ff < cnt_type'(2)) begin
                  hold_status_in = STATUS_FEW;
               end else begin
                  // marker: all-ones hold word plus matching swap_b selects swap in ST_READ
                  hold_pop_in = '1;
                  swap_b_in   = step_fwd(front_ff);
                  state_in    = ST_READ;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_pop_ff    <= hold_pop_in;
      hold_status_ff <= hold_status_in;
      swap_b_ff      <= swap_b_in;
      rsp_pop_ff     <= rsp_pop_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pop_value = rsp_pop_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.count     = rsp_count_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_ptr_meet : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> front_ff == back_ff)
      else $error("pointers disagree with empty/full count");

   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (accept && !empty && (req_chan.kind == KIND_POP_FRONT
                            || req_chan.kind == KIND_POP_BACK))
      |=> count_ff == cnt_type'($past(count_ff) - 1'b1))
      else $error("pop did not drop count by one");

   a_swap_done : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWAP |=> state_ff == ST_DONE)
      else $error("swap second write not followed by response");

   a_done_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !out_free) |=> state_ff == ST_DONE)
      else $error("pending response dropped under stall");

endmodule

`default_nettype wire

// ===== src/rbd_ram.sv =====
// rbd_ram: generic RAM, one write port and two read ports, registered read data.
// No package dependencies.
`default_nettype none

module rbd_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 9,
   parameter int DEPTH  = 512
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr_a,
   input  wire logic [ADDR_W-1:0] raddr_b,
   output logic      [DATA_W-1:0] rdata_a,
   output logic      [DATA_W-1:0] rdata_b
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

`default_nettype wire
